/* src/bds_pkg.sv */
// ----------------------------------------------------------------------------
// bds_pkg
// Shared types, constants and helper functions of the 3x3 box downsampler.
// ----------------------------------------------------------------------------
package bds_pkg;

    // Largest number of output columns kept in the band store.
    localparam int MAX_OUT_WIDTH = 1024;
    localparam int OUT_ADDR_W    = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

    localparam int CH_W   = 8;    // one color channel
    localparam int COL_W  = 12;   // source column counter and source width
    localparam int HS_W   = 10;   // horizontal sum of three pixels, one channel
    localparam int BS_W   = 12;   // sum over a 3x3 block, one channel
    localparam int OC_W   = $clog2((2 ** COL_W) / 3 + 1);  // output column index
    localparam int PROD_W = 2 * BS_W;
    localparam int QUO_W  = BS_W - 3;  // a 12-bit sum over nine fits in 9 bits

    // x / 3 == (x * 2731) >> 13 for every 12-bit x.
    localparam logic [COL_W-1:0] RECIP3       = 12'd2731;
    localparam int               RECIP3_SHIFT = 13;
    // x / 9 == (x * 3641) >> 15 for every 12-bit x.
    localparam logic [BS_W-1:0]  RECIP9       = 12'd3641;
    localparam int               RECIP9_SHIFT = 15;

    localparam logic [QUO_W-1:0] WHITE_LEVEL = 9'd255;
    localparam logic [CH_W-1:0]  GRID_GRAY   = 8'd128;

    typedef enum logic [0:0] {
        REG_SOURCE_WIDTH = 1'b0,
        REG_GRID_ENABLE  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic            frame_start;
        logic [CH_W-1:0] src_red;
        logic [CH_W-1:0] src_green;
        logic [CH_W-1:0] src_blue;
        logic [CH_W-1:0] grid_red;
        logic [CH_W-1:0] grid_green;
        logic [CH_W-1:0] grid_blue;
    } pixel_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic            grid_applied;
        logic            row_end;
    } result_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [HS_W-1:0] red;
        logic [HS_W-1:0] green;
        logic [HS_W-1:0] blue;
    } hsum_t;

    typedef struct packed {
        logic [BS_W-1:0] red;
        logic [BS_W-1:0] green;
        logic [BS_W-1:0] blue;
    } band_t;

    // A finished run of three pixels headed for the band store.
    typedef struct packed {
        hsum_t                 hsum;
        logic [OUT_ADDR_W-1:0] oc;
        logic [1:0]            row_phase;
        logic                  row_end;
        rgb_t                  grid;
    } band_req_t;

    // A finished 3x3 block headed for the divider.
    typedef struct packed {
        band_t sum;
        logic  row_end;
        rgb_t  grid;
    } mean_req_t;

    function automatic logic [OC_W-1:0] div3(input logic [COL_W-1:0] x);
        logic [2*COL_W-1:0] p;
        p = x * RECIP3;
        return p[RECIP3_SHIFT +: OC_W];
    endfunction

endpackage

/* src/bds_ram.sv */
// ----------------------------------------------------------------------------
// bds_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module bds_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/bds_front.sv */
// ----------------------------------------------------------------------------
// bds_front
// Configuration registers, column and row counters, and the horizontal sum
// over each run of three source pixels.
// ----------------------------------------------------------------------------
module bds_front
    import bds_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    output logic             pixel_stall,
    input  pixel_t           pixel,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  cfg_reg_t         cfg_index,
    input  logic [COL_W-1:0] cfg_data,
    input  logic             band_ready,
    output logic             band_enter,
    output band_req_t        band_req,
    output logic             grid_enable
);

    logic [COL_W-1:0] source_width_reg, source_width_next;
    logic [OC_W-1:0]  out_width_reg, out_width_next;
    logic             grid_enable_reg, grid_enable_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [1:0]       ph_reg, ph_next;
    logic [OC_W-1:0]  oc_reg, oc_next;
    logic [1:0]       row_phase_reg, row_phase_next;
    hsum_t            hsum_reg, hsum_next;

    logic             accept;
    logic [COL_W-1:0] col;
    logic [1:0]       ph;
    logic [OC_W-1:0]  oc;
    logic [1:0]       row_phase;
    hsum_t            hsum_prev;
    hsum_t            hsum_new;
    logic             in_window;
    logic             row_wrap;
    logic [OC_W-1:0]  width_quot;

    assign cfg_ready   = 1'b1;
    assign grid_enable = grid_enable_reg;
    assign accept      = pixel_valid && band_ready;
    assign pixel_stall = !band_ready;

    // A frame start clears the counters before its own pixel is used.
    assign col       = pixel.frame_start ? '0 : col_reg;
    assign ph        = pixel.frame_start ? '0 : ph_reg;
    assign oc        = pixel.frame_start ? '0 : oc_reg;
    assign row_phase = pixel.frame_start ? '0 : row_phase_reg;
    assign hsum_prev = (pixel.frame_start || ph == 2'd0) ? '0 : hsum_reg;

    assign in_window = oc < out_width_reg;
    assign row_wrap  = ({1'b0, col} + 1'b1) >= {1'b0, source_width_reg};

    always_comb
    begin
        hsum_new.red   = {2'b00, pixel.src_red}   + hsum_prev.red;
        hsum_new.green = {2'b00, pixel.src_green} + hsum_prev.green;
        hsum_new.blue  = {2'b00, pixel.src_blue}  + hsum_prev.blue;
    end

    assign band_enter         = accept && in_window && ph == 2'd2;
    assign band_req.hsum      = hsum_new;
    assign band_req.oc        = OUT_ADDR_W'(oc);
    assign band_req.row_phase = row_phase;
    assign band_req.row_end   = (oc + 1'b1) == out_width_reg;
    assign band_req.grid      = '{red: pixel.grid_red, green: pixel.grid_green,
                                  blue: pixel.grid_blue};

    assign width_quot = div3(cfg_data);

    always_comb
    begin
        source_width_next = source_width_reg;
        out_width_next    = out_width_reg;
        grid_enable_next  = grid_enable_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:
                begin
                    source_width_next = cfg_data;
                    if (int'(width_quot) > MAX_OUT_WIDTH)
                    begin
                        out_width_next = OC_W'(MAX_OUT_WIDTH);
                    end
                    else
                    begin
                        out_width_next = width_quot;
                    end
                end
                REG_GRID_ENABLE:
                begin
                    grid_enable_next = cfg_data[0];
                end
            endcase
        end
    end

    always_comb
    begin
        col_next       = col_reg;
        ph_next        = ph_reg;
        oc_next        = oc_reg;
        row_phase_next = row_phase_reg;
        hsum_next      = hsum_reg;
        if (accept)
        begin
            // Outside the window the running sum is kept, unless a frame starts.
            hsum_next = in_window ? hsum_new : (pixel.frame_start ? '0 : hsum_reg);
            if (row_wrap)
            begin
                col_next       = '0;
                ph_next        = '0;
                oc_next        = '0;
                row_phase_next = (row_phase >= 2'd2) ? 2'd0 : row_phase + 2'd1;
            end
            else
            begin
                col_next       = col + 1'b1;
                row_phase_next = row_phase;
                if (ph == 2'd2)
                begin
                    ph_next = 2'd0;
                    oc_next = oc + 1'b1;
                end
                else
                begin
                    ph_next = ph + 2'd1;
                    oc_next = oc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg <= COL_W'(3);
            out_width_reg    <= OC_W'(1);
            grid_enable_reg  <= 1'b0;
            col_reg          <= '0;
            ph_reg           <= '0;
            oc_reg           <= '0;
            row_phase_reg    <= '0;
            hsum_reg         <= '0;
        end
        else
        begin
            source_width_reg <= source_width_next;
            out_width_reg    <= out_width_next;
            grid_enable_reg  <= grid_enable_next;
            col_reg          <= col_next;
            ph_reg           <= ph_next;
            oc_reg           <= oc_next;
            row_phase_reg    <= row_phase_next;
            hsum_reg         <= hsum_next;
        end
    end

endmodule

/* src/bds_band.sv */
// ----------------------------------------------------------------------------
// bds_band
// Band store stage: reads the column's partial block sum, adds the new
// horizontal sum and writes it back, forwarding a write that lands on the
// entry being read in the same cycle.
// ----------------------------------------------------------------------------
module bds_band
    import bds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      enter,
    input  band_req_t req,
    output logic      ready,
    output logic      mean_valid,
    input  logic      mean_ready,
    output mean_req_t mean_req
);

    logic      stage_valid_reg, stage_valid_next;
    band_req_t stage_reg, stage_next;
    logic      fwd_hit_reg, fwd_hit_next;
    band_t     fwd_data_reg, fwd_data_next;

    logic      [$bits(band_t)-1:0] ram_rd_data;
    band_t     prior;
    band_t     sum;
    logic      last_row;
    logic      leave;

    bds_ram #(
        .WIDTH ($bits(band_t)),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_band_ram (
        .clk     (clk),
        .wr_en   (leave),
        .wr_addr (stage_reg.oc),
        .wr_data (sum),
        .rd_en   (enter),
        .rd_addr (req.oc),
        .rd_data (ram_rd_data)
    );

    assign prior    = fwd_hit_reg ? fwd_data_reg : band_t'(ram_rd_data);
    assign last_row = stage_reg.row_phase == 2'd2;

    // The first row of a band starts the block sum afresh.
    always_comb
    begin
        if (stage_reg.row_phase == 2'd0)
        begin
            sum.red   = {2'b00, stage_reg.hsum.red};
            sum.green = {2'b00, stage_reg.hsum.green};
            sum.blue  = {2'b00, stage_reg.hsum.blue};
        end
        else
        begin
            sum.red   = {2'b00, stage_reg.hsum.red}   + prior.red;
            sum.green = {2'b00, stage_reg.hsum.green} + prior.green;
            sum.blue  = {2'b00, stage_reg.hsum.blue}  + prior.blue;
        end
    end

    assign leave      = stage_valid_reg && (!last_row || mean_ready);
    assign ready      = !stage_valid_reg || leave;
    assign mean_valid = stage_valid_reg && last_row;
    assign mean_req   = '{sum: sum, row_end: stage_reg.row_end, grid: stage_reg.grid};

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        fwd_hit_next     = fwd_hit_reg;
        fwd_data_next    = fwd_data_reg;
        if (enter)
        begin
            stage_valid_next = 1'b1;
            stage_next       = req;
            // The RAM returns the old word when the same entry is written
            // in this cycle, so keep the new word aside.
            fwd_hit_next     = leave && stage_reg.oc == req.oc;
            fwd_data_next    = sum;
        end
        else if (leave)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            fwd_hit_reg     <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            fwd_hit_reg     <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg    <= stage_next;
        fwd_data_reg <= fwd_data_next;
    end

endmodule

/* src/bds_mean.sv */
// ----------------------------------------------------------------------------
// bds_mean
// Divides each block sum by nine with a reciprocal multiply, applies the
// grid overlay and holds the result in the output register.
// ----------------------------------------------------------------------------
module bds_mean
    import bds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      valid,
    output logic      ready,
    input  mean_req_t req,
    input  logic      grid_enable,
    output logic      result_valid,
    input  logic      result_stall,
    output result_t   result
);

    logic              c_valid_reg, c_valid_next;
    mean_req_t         c_reg, c_next;
    logic              d_valid_reg, d_valid_next;
    logic [PROD_W-1:0] d_red_reg, d_red_next;
    logic [PROD_W-1:0] d_green_reg, d_green_next;
    logic [PROD_W-1:0] d_blue_reg, d_blue_next;
    logic              d_row_end_reg, d_row_end_next;
    rgb_t              d_grid_reg, d_grid_next;
    logic              result_valid_reg, result_valid_next;
    result_t           result_reg, result_next;

    logic              out_free;
    logic              d_free;
    logic              c_free;
    logic [QUO_W-1:0]  q_red;
    logic [QUO_W-1:0]  q_green;
    logic [QUO_W-1:0]  q_blue;
    logic              apply_grid;

    assign out_free = !result_valid_reg || !result_stall;
    assign d_free   = !d_valid_reg || out_free;
    assign c_free   = !c_valid_reg || d_free;
    assign ready    = c_free;

    assign q_red   = d_red_reg[RECIP9_SHIFT +: QUO_W];
    assign q_green = d_green_reg[RECIP9_SHIFT +: QUO_W];
    assign q_blue  = d_blue_reg[RECIP9_SHIFT +: QUO_W];

    assign apply_grid = grid_enable
        && q_red == WHITE_LEVEL && q_green == WHITE_LEVEL && q_blue == WHITE_LEVEL
        && d_grid_reg.red == GRID_GRAY && d_grid_reg.green == GRID_GRAY
        && d_grid_reg.blue == GRID_GRAY;

    always_comb
    begin
        c_valid_next = c_valid_reg;
        c_next       = c_reg;
        if (valid && c_free)
        begin
            c_valid_next = 1'b1;
            c_next       = req;
        end
        else if (d_free)
        begin
            c_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        d_valid_next   = d_valid_reg;
        d_red_next     = d_red_reg;
        d_green_next   = d_green_reg;
        d_blue_next    = d_blue_reg;
        d_row_end_next = d_row_end_reg;
        d_grid_next    = d_grid_reg;
        if (c_valid_reg && d_free)
        begin
            d_valid_next   = 1'b1;
            d_red_next     = c_reg.sum.red * RECIP9;
            d_green_next   = c_reg.sum.green * RECIP9;
            d_blue_next    = c_reg.sum.blue * RECIP9;
            d_row_end_next = c_reg.row_end;
            d_grid_next    = c_reg.grid;
        end
        else if (out_free)
        begin
            d_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (d_valid_reg && out_free)
        begin
            result_valid_next = 1'b1;
            if (apply_grid)
            begin
                result_next.out_red   = d_grid_reg.red;
                result_next.out_green = d_grid_reg.green;
                result_next.out_blue  = d_grid_reg.blue;
            end
            else
            begin
                result_next.out_red   = q_red[CH_W-1:0];
                result_next.out_green = q_green[CH_W-1:0];
                result_next.out_blue  = q_blue[CH_W-1:0];
            end
            result_next.grid_applied = apply_grid;
            result_next.row_end      = d_row_end_reg;
        end
        else if (out_free)
        begin
            result_valid_next = 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg      <= 1'b0;
            d_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg      <= c_valid_next;
            d_valid_reg      <= d_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg         <= c_next;
        d_red_reg     <= d_red_next;
        d_green_reg   <= d_green_next;
        d_blue_reg    <= d_blue_next;
        d_row_end_reg <= d_row_end_next;
        d_grid_reg    <= d_grid_next;
        result_reg    <= result_next;
    end

endmodule

/* src/box_downsample_3x3_grid_overlay.sv */
// ----------------------------------------------------------------------------
// box_downsample_3x3_grid_overlay
// 3x3 box-filter downsampler for 24-bit RGB with an optional grid overlay.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order at one per clock; the block stalls the
// source only when the result side has held off long enough to fill the
// four internal stages. Each run of three pixels is summed in a register,
// and the partial block sums of every output column live in a 1024-entry
// band RAM that is read, added to and written back once per three pixels.
// The pixel that completes a 3x3 block is carried through the band RAM read,
// the block-sum register, the reciprocal multiply by nine and the overlay
// into the output register. The band RAM is never cleared; the first row of
// each band overwrites its entries. Write source_width and grid_enable only
// while no pixel is in flight.
// ----------------------------------------------------------------------------
module box_downsample_3x3_grid_overlay
    import bds_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    output logic             pixel_stall,
    input  pixel_t           pixel,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  cfg_reg_t         cfg_index,
    input  logic [COL_W-1:0] cfg_data
);

    logic      band_ready;
    logic      band_enter;
    band_req_t band_req;
    logic      grid_enable;
    logic      mean_valid;
    logic      mean_ready;
    mean_req_t mean_req;

    bds_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .band_ready  (band_ready),
        .band_enter  (band_enter),
        .band_req    (band_req),
        .grid_enable (grid_enable)
    );

    bds_band u_band (
        .clk        (clk),
        .rst_n      (rst_n),
        .enter      (band_enter),
        .req        (band_req),
        .ready      (band_ready),
        .mean_valid (mean_valid),
        .mean_ready (mean_ready),
        .mean_req   (mean_req)
    );

    bds_mean u_mean (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (mean_valid),
        .ready        (mean_ready),
        .req          (mean_req),
        .grid_enable  (grid_enable),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* tb/box_downsample_3x3_grid_overlay_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downsample_3x3_grid_overlay_tb
// Self-checking bench for the 3x3 box downsampler with grid overlay.
// ----------------------------------------------------------------------------
// A queue of source pixels feeds a bursty driver. Every accepted pixel runs
// through a behavioral copy of the downsampler, which queues the block mean
// it should produce. A monitor compares each result transfer with the oldest
// queued mean. Register writes happen only with the pipeline drained. The
// stimulus covers the reset width, a long result hold-off, a column that
// lands past a reduced width, a width above the line store size, narrow
// widths and a long run of random frames.
// ----------------------------------------------------------------------------
module box_downsample_3x3_grid_overlay_tb;
    import bds_pkg::*;

    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLDOFF_CYCLES = 150;
    localparam int RAND_ITEMS     = 500;
    localparam int WIDE_WIDTH     = 3075;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             pixel_valid  = 1'b0;
    logic             pixel_stall;
    pixel_t           pixel        = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    result_t          result;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    cfg_reg_t         cfg_index    = REG_SOURCE_WIDTH;
    logic [COL_W-1:0] cfg_data     = '0;

    box_downsample_3x3_grid_overlay dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    pixel_t  pend_q[$];
    result_t mean_q[$];
    result_t want;
    int      px_queued = 0;
    int      px_taken  = 0;
    int      fail_cnt  = 0;

    // Behavioral state of the downsampler.
    logic [COL_W-1:0] cur_width  = 12'd3;
    logic             cur_grid_en = 1'b0;
    logic [COL_W-1:0] col_pos    = '0;
    logic [1:0]       band_row   = '0;
    logic [HS_W-1:0]  run_sum [3] = '{default: '0};
    logic [BS_W-1:0]  band_mem [MAX_OUT_WIDTH][3];

    // Sender and receiver pacing.
    int burst_left     = 0;
    int gap_left       = 0;
    bit steady_send    = 1'b0;
    int holdoff_asked  = 0;
    int holdoff_served = 0;
    int holdoff_left   = 0;
    int stall_mode     = 0;
    int mode_left      = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        foreach (band_mem[i])
        begin
            band_mem[i] = '{default: '0};
        end
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void predict_block_mean(pixel_t px);
        logic [CH_W-1:0] src [3];
        logic [CH_W-1:0] grd [3];
        logic [BS_W-1:0] tot [3];
        logic [8:0]      avg [3];
        int unsigned     outw;
        int unsigned     col;
        int unsigned     oc;
        int unsigned     ph;
        bit              applied;
        result_t         r;
        src = '{px.src_red, px.src_green, px.src_blue};
        grd = '{px.grid_red, px.grid_green, px.grid_blue};
        if (px.frame_start)
        begin
            col_pos  = '0;
            band_row = '0;
            run_sum  = '{default: '0};
        end
        outw = cur_width / 3;
        if (outw > MAX_OUT_WIDTH)
        begin
            outw = MAX_OUT_WIDTH;
        end
        col = col_pos;
        oc  = col / 3;
        ph  = col % 3;
        if (oc < outw)
        begin
            for (int c = 0; c < 3; c++)
            begin
                run_sum[c] = src[c] + ((ph == 0) ? 10'd0 : run_sum[c]);
            end
            if (ph == 2)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    tot[c] = run_sum[c] + ((band_row != 0) ? band_mem[oc][c] : 12'd0);
                    band_mem[oc][c] = tot[c];
                    avg[c] = 9'(tot[c] / 9);
                end
                if (band_row == 2)
                begin
                    // Only a pure white mean over an exact mid-gray grid pixel is replaced.
                    applied = cur_grid_en && avg[0] == 255 && avg[1] == 255 && avg[2] == 255
                              && grd[0] == GRID_GRAY && grd[1] == GRID_GRAY
                              && grd[2] == GRID_GRAY;
                    r.out_red      = applied ? grd[0] : avg[0][7:0];
                    r.out_green    = applied ? grd[1] : avg[1][7:0];
                    r.out_blue     = applied ? grd[2] : avg[2][7:0];
                    r.grid_applied = applied;
                    r.row_end      = (oc + 1 == outw);
                    mean_q.push_back(r);
                end
            end
        end
        if (col + 1 >= cur_width)
        begin
            col_pos  = '0;
            band_row = (band_row >= 2) ? 2'd0 : band_row + 2'd1;
        end
        else
        begin
            col_pos = COL_W'(col + 1);
        end
    endfunction

    // Source side: bursts of random length with random gaps in between, no gaps while steady_send is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            pixel       <= '0;
        end
        else
        begin
            if (pixel_valid && !pixel_stall)
            begin
                predict_block_mean(pixel);
                px_taken++;
            end
            if (!pixel_valid || !pixel_stall)
            begin
                if (gap_left != 0 && !steady_send)
                begin
                    gap_left--;
                    pixel_valid <= 1'b0;
                end
                else if (pend_q.size() != 0)
                begin
                    pixel       <= pend_q.pop_front();
                    pixel_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    pixel_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: a stall pattern of its own, or a long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (holdoff_asked != holdoff_served)
            begin
                holdoff_served++;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left != 0)
            begin
                holdoff_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(10, 80);
                end
                else
                begin
                    mode_left--;
                end
                case (stall_mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 99) < 30);
                    2: result_stall <= ($urandom_range(0, 99) < 70);
                    default: result_stall <= ~result_stall;
                endcase
            end
        end
    end

    function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] got);
        if (got !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (mean_q.size() == 0)
            begin
                $error("result transfer with no expected mean waiting");
                fail_cnt++;
            end
            else
            begin
                want = mean_q.pop_front();
                check_field("out_red", want.out_red, result.out_red);
                check_field("out_green", want.out_green, result.out_green);
                check_field("out_blue", want.out_blue, result.out_blue);
                check_field("grid_applied", want.grid_applied, result.grid_applied);
                check_field("row_end", want.row_end, result.row_end);
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [COL_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SOURCE_WIDTH: cur_width = val;
            REG_GRID_ENABLE:  cur_grid_en = val[0];
            default: ;
        endcase
    endtask

    // Waits until every queued pixel is taken and every mean has come out,
    // then lets the pipeline settle for pixels that produce no result.
    task automatic drain_block();
        do @(posedge clk); while (px_taken != px_queued || mean_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_pixel(pixel_t p);
        pend_q.push_back(p);
        px_queued++;
    endtask

    function automatic pixel_t make_pixel(logic fs, int white_pct, int gray_pct);
        pixel_t p;
        p.frame_start = fs;
        if ($urandom_range(0, 99) < white_pct)
        begin
            p.src_red   = 8'd255;
            p.src_green = 8'd255;
            p.src_blue  = 8'd255;
            // A single channel just below white keeps the mean off full white.
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: p.src_red = 8'd254;
                    1: p.src_green = 8'd254;
                    default: p.src_blue = 8'd254;
                endcase
            end
        end
        else
        begin
            p.src_red   = CH_W'($urandom_range(0, 255));
            p.src_green = CH_W'($urandom_range(0, 255));
            p.src_blue  = CH_W'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 99) < gray_pct)
        begin
            p.grid_red   = GRID_GRAY;
            p.grid_green = GRID_GRAY;
            p.grid_blue  = GRID_GRAY;
            if ($urandom_range(0, 7) == 0)
            begin
                p.grid_blue = CH_W'($urandom_range(0, 255));
            end
        end
        else
        begin
            p.grid_red   = CH_W'($urandom_range(0, 255));
            p.grid_green = CH_W'($urandom_range(0, 255));
            p.grid_blue  = CH_W'($urandom_range(0, 255));
        end
        return p;
    endfunction

    // A run of pixels; noise_pm is the per-mille chance of a stray frame start.
    task automatic push_run(int count, bit fs_first, int white_pct, int gray_pct, int noise_pm);
        for (int n = 0; n < count; n++)
        begin
            push_pixel(make_pixel((n == 0) ? fs_first : ($urandom_range(0, 999) < noise_pm),
                                  white_pct, gray_pct));
        end
    endtask

    task automatic push_block(logic [CH_W-1:0] src, logic [CH_W-1:0] grid_last);
        pixel_t p;
        for (int n = 0; n < 9; n++)
        begin
            p = make_pixel(n == 0, 0, 0);
            p.src_red   = src;
            p.src_green = src;
            p.src_blue  = src;
            if (n == 8)
            begin
                p.grid_red   = grid_last;
                p.grid_green = grid_last;
                p.grid_blue  = grid_last;
            end
            push_pixel(p);
        end
    endtask

    initial
    begin
        int rand_items;
        int w;
        int g;
        int sel;
        int white;
        int gray;
        int cnt;
        int rows;
        bit fresh;
        rand_items = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Width of three with the overlay on: one block per frame.
        write_reg(REG_SOURCE_WIDTH, 12'd3);
        write_reg(REG_GRID_ENABLE, 12'd1);
        push_block(8'd255, GRID_GRAY);
        push_block(8'd0, 8'd255);
        // A band cut short, dropped by the next frame start.
        push_run(4, 1'b1, 50, 50, 0);
        drain_block();

        // Long result hold-off while pixels keep coming, so the input stalls.
        steady_send = 1'b1;
        holdoff_asked++;
        push_run(200, 1'b1, 60, 60, 0);
        drain_block();
        steady_send = 1'b0;

        // Column counter left past a reduced width wraps and ends the row.
        write_reg(REG_SOURCE_WIDTH, 12'd30);
        push_run(50, 1'b1, 50, 50, 0);
        drain_block();
        write_reg(REG_SOURCE_WIDTH, 12'd12);
        push_run(25, 1'b0, 50, 50, 0);
        drain_block();

        // Widths above the line store size on their first columns.
        write_reg(REG_GRID_ENABLE, 12'd0);
        write_reg(REG_SOURCE_WIDTH, COL_W'(WIDE_WIDTH));
        push_run(60, 1'b1, 30, 50, 0);
        drain_block();
        write_reg(REG_SOURCE_WIDTH, 12'hFFF);
        push_run(30, 1'b1, 30, 50, 0);
        drain_block();

        while (rand_items < RAND_ITEMS)
        begin
            sel = $urandom_range(0, 15);
            if (sel == 0)
                w = $urandom_range(0, 2);
            else if (sel == 1)
                w = 3;
            else if (sel <= 12)
                w = $urandom_range(3, 21);
            else if (sel <= 14)
                w = $urandom_range(22, 60);
            else
                w = $urandom_range(61, 150);
            g = $urandom_range(0, 1);
            case ($urandom_range(0, 2))
                0: white = 0;
                1: white = 40;
                default: white = 95;
            endcase
            case ($urandom_range(0, 2))
                0: gray = 10;
                1: gray = 60;
                default: gray = 95;
            endcase
            write_reg(REG_SOURCE_WIDTH, COL_W'(w));
            write_reg(REG_GRID_ENABLE, COL_W'(g));
            fresh = 1'b1;
            for (int f = $urandom_range(1, 3); f > 0; f--)
            begin
                if (w < 3)
                begin
                    cnt = $urandom_range(4, 16);
                end
                else
                begin
                    rows = (w > 60) ? 3 : $urandom_range(1, 7);
                    cnt  = rows * w;
                    if ($urandom_range(0, 4) == 0)
                        cnt = $urandom_range(1, cnt);
                end
                // A new width always starts with a frame start; later frames may omit it.
                push_run(cnt, (fresh || $urandom_range(0, 9) != 0), white, gray, 5);
                fresh = 1'b0;
                rand_items += cnt;
            end
            drain_block();
        end

        drain_block();
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
